// File: rtl/content_type_header_parser_macros.svh
// Assertion macros shared by the Content-Type header parser RTL.
// Depends on nothing; the using module must provide clk and arst_n.
`ifndef CONTENT_TYPE_HEADER_PARSER_MACROS_SVH
`define CONTENT_TYPE_HEADER_PARSER_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define CTHP_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("content type parser check failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define CTHP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("content type parser check failed");

`endif

// File: rtl/cthp_pkg.sv
// Package for the Content-Type header parser: limits, phase codes, payload types
// and character class helpers. Depends on nothing.
package cthp_pkg;

	localparam int MAX_PARAMS      = 8;
	localparam int TYPE_MAX_LEN    = 31;
	localparam int SUBTYPE_MAX_LEN = 31;
	localparam int NAME_MAX_LEN    = 31;
	localparam int VALUE_MAX_LEN   = 63;
	localparam int CHARSET_MAX_LEN = 31;

	localparam logic [3:0] PH_LEAD   = 4'd0;
	localparam logic [3:0] PH_TYPE   = 4'd1;
	localparam logic [3:0] PH_SUB0   = 4'd2;
	localparam logic [3:0] PH_SUB    = 4'd3;
	localparam logic [3:0] PH_AFTER  = 4'd4;
	localparam logic [3:0] PH_NAME0  = 4'd5;
	localparam logic [3:0] PH_NAME   = 4'd6;
	localparam logic [3:0] PH_EQ     = 4'd7;
	localparam logic [3:0] PH_VAL0   = 4'd8;
	localparam logic [3:0] PH_VTOK   = 4'd9;
	localparam logic [3:0] PH_QUOTED = 4'd10;
	localparam logic [3:0] PH_ESC    = 4'd11;
	localparam logic [3:0] PH_ERR    = 4'd12;

	localparam logic [3:0] CS_MISS = 4'd15;
	localparam logic [3:0] CS_FULL = 4'd7;

	localparam logic [1:0] KIND_TYPE    = 2'd0;
	localparam logic [1:0] KIND_SUBTYPE = 2'd1;
	localparam logic [1:0] KIND_NAME    = 2'd2;
	localparam logic [1:0] KIND_VALUE   = 2'd3;

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_EQUALS = 8'h3D;
	localparam logic [7:0] CH_DEL    = 8'h7F;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_byte;
	} hdr_item_t;

	typedef struct packed {
		logic       char_valid;
		logic [1:0] char_kind;
		logic [7:0] out_char;
		logic [7:0] lowered_char;
		logic [2:0] param_index;
		logic       param_kept;
		logic       is_charset;
		logic       done_res;
		logic       accepted;
		logic [7:0] param_count;
	} res_item_t;

	typedef struct packed {
		logic [3:0] phase;
		logic [5:0] comp_len;
		logic [3:0] cs_match;
		logic       value_cs;
		logic [7:0] param_total;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		phase: PH_LEAD, comp_len: 6'd0, cs_match: 4'd0, value_cs: 1'b0, param_total: 8'd0
	};

	function automatic logic [7:0] lower8(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB;
	endfunction

	function automatic logic is_tok(input logic [7:0] c);
		logic res;
		res = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h30 && c <= 8'h39);
		case (c)
			8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
			8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: res = 1'b1;
			default: ;
		endcase
		return res;
	endfunction

	function automatic logic [7:0] charset_letter(input logic [2:0] p);
		logic [7:0] res;
		case (p)
			3'd0: res = 8'h63;
			3'd1: res = 8'h68;
			3'd2: res = 8'h61;
			3'd3: res = 8'h72;
			3'd4: res = 8'h73;
			3'd5: res = 8'h65;
			3'd6: res = 8'h74;
			default: res = 8'h00;
		endcase
		return res;
	endfunction

endpackage

// File: rtl/cthp_step.sv
// Per-byte next-state and result logic of the Content-Type header parser.
// Purely combinational; depends on cthp_pkg.
module cthp_step (
	input  cthp_pkg::parse_state_t cur,
	input  cthp_pkg::hdr_item_t    item,
	output cthp_pkg::parse_state_t nxt,
	output cthp_pkg::res_item_t    res
);
	import cthp_pkg::*;

	logic [7:0] b;
	logic [7:0] lc;
	logic       want_grow;
	logic       name_upd;
	logic [5:0] base_len;
	logic [5:0] lim;
	logic [3:0] cs_base;
	logic [1:0] kind;
	logic [7:0] ch;
	logic       cs_flag;
	logic       ok;

	assign b  = item.in_byte;
	assign lc = lower8(b);

	always_comb begin
		nxt       = cur;
		res       = '0;
		want_grow = 1'b0;
		name_upd  = 1'b0;
		base_len  = cur.comp_len;
		lim       = 6'(TYPE_MAX_LEN);
		cs_base   = cur.cs_match;
		kind      = KIND_TYPE;
		ch        = lc;
		ok        = 1'b0;

		unique case (cur.phase)
			PH_LEAD: begin
				if (is_tok(b)) begin
					nxt.phase = PH_TYPE;
					base_len  = 6'd0;
					want_grow = 1'b1;
				end else if (!is_blank(b)) begin
					nxt.phase = PH_ERR;
				end
			end
			PH_TYPE: begin
				if (is_tok(b)) begin
					want_grow = 1'b1;
				end else if (b == CH_SLASH) begin
					nxt.phase = PH_SUB0;
				end else begin
					nxt.phase = PH_ERR;
				end
			end
			PH_SUB0: begin
				if (is_tok(b)) begin
					nxt.phase = PH_SUB;
					base_len  = 6'd0;
					lim       = 6'(SUBTYPE_MAX_LEN);
					kind      = KIND_SUBTYPE;
					want_grow = 1'b1;
				end else begin
					nxt.phase = PH_ERR;
				end
			end
			PH_SUB: begin
				lim  = 6'(SUBTYPE_MAX_LEN);
				kind = KIND_SUBTYPE;
				if (is_tok(b)) begin
					want_grow = 1'b1;
				end else if (is_blank(b)) begin
					nxt.phase = PH_AFTER;
				end else if (b == CH_SEMI) begin
					nxt.phase = PH_NAME0;
				end else begin
					nxt.phase = PH_ERR;
				end
			end
			PH_AFTER: begin
				if (!is_blank(b)) begin
					nxt.phase = (b == CH_SEMI) ? PH_NAME0 : PH_ERR;
				end
			end
			PH_NAME0: begin
				lim  = 6'(NAME_MAX_LEN);
				kind = KIND_NAME;
				if (is_tok(b)) begin
					nxt.phase    = PH_NAME;
					base_len     = 6'd0;
					cs_base      = 4'd0;
					nxt.cs_match = 4'd0;
					want_grow    = 1'b1;
					name_upd     = 1'b1;
				end else if (!is_blank(b)) begin
					nxt.phase = PH_ERR;
				end
			end
			PH_NAME: begin
				lim  = 6'(NAME_MAX_LEN);
				kind = KIND_NAME;
				if (is_tok(b)) begin
					want_grow = 1'b1;
					name_upd  = 1'b1;
				end else if (is_blank(b)) begin
					nxt.value_cs = (cur.cs_match == CS_FULL);
					nxt.phase    = PH_EQ;
				end else if (b == CH_EQUALS) begin
					nxt.value_cs = (cur.cs_match == CS_FULL);
					nxt.phase    = PH_VAL0;
				end else begin
					nxt.phase = PH_ERR;
				end
			end
			PH_EQ: begin
				if (!is_blank(b)) begin
					nxt.phase = (b == CH_EQUALS) ? PH_VAL0 : PH_ERR;
				end
			end
			PH_VAL0: begin
				lim  = 6'(VALUE_MAX_LEN);
				kind = KIND_VALUE;
				ch   = b;
				if (!is_blank(b)) begin
					nxt.comp_len = 6'd0;
					base_len     = 6'd0;
					if (b == CH_DQUOTE) begin
						nxt.phase = PH_QUOTED;
					end else if (is_tok(b)) begin
						nxt.phase = PH_VTOK;
						want_grow = 1'b1;
					end else begin
						nxt.phase = PH_ERR;
					end
				end
			end
			PH_VTOK: begin
				lim  = 6'(VALUE_MAX_LEN);
				kind = KIND_VALUE;
				ch   = b;
				if (is_tok(b)) begin
					want_grow = 1'b1;
				end else if (is_blank(b) || b == CH_SEMI) begin
					if (cur.param_total != 8'hFF) begin
						nxt.param_total = cur.param_total + 8'd1;
					end
					nxt.phase = is_blank(b) ? PH_AFTER : PH_NAME0;
				end else begin
					nxt.phase = PH_ERR;
				end
			end
			PH_QUOTED: begin
				lim  = 6'(VALUE_MAX_LEN);
				kind = KIND_VALUE;
				ch   = b;
				if (b == CH_DQUOTE) begin
					if (cur.param_total != 8'hFF) begin
						nxt.param_total = cur.param_total + 8'd1;
					end
					nxt.phase = PH_AFTER;
				end else if (b == CH_BSLASH) begin
					nxt.phase = PH_ESC;
				end else if (b < CH_SPACE && b != CH_TAB) begin
					nxt.phase = PH_ERR;
				end else begin
					want_grow = 1'b1;
				end
			end
			PH_ESC: begin
				lim  = 6'(VALUE_MAX_LEN);
				kind = KIND_VALUE;
				ch   = b;
				if (b < CH_SPACE || b == CH_DEL) begin
					nxt.phase = PH_ERR;
				end else begin
					nxt.phase = PH_QUOTED;
					want_grow = 1'b1;
				end
			end
			default: begin
				nxt.phase = PH_ERR;
			end
		endcase

		cs_flag = cur.value_cs && (base_len < 6'(CHARSET_MAX_LEN));

		if (want_grow) begin
			if (base_len >= lim || base_len == 6'd63) begin
				nxt.phase = PH_ERR;
			end else begin
				nxt.comp_len     = base_len + 6'd1;
				res.char_valid   = 1'b1;
				res.char_kind    = kind;
				res.out_char     = ch;
				res.lowered_char = lower8(ch);
				if (kind == KIND_NAME || kind == KIND_VALUE) begin
					res.param_index = cur.param_total[2:0];
					res.param_kept  = (cur.param_total < 8'(MAX_PARAMS));
					res.is_charset  = (kind == KIND_VALUE) && cs_flag;
				end
				if (name_upd) begin
					if (cs_base != CS_MISS && cs_base == {2'b00, base_len[1:0]} + {base_len[3:2], 2'b00}
						&& base_len < 6'd7 && lc == charset_letter(base_len[2:0])) begin
						nxt.cs_match = 4'(base_len) + 4'd1;
					end else begin
						nxt.cs_match = CS_MISS;
					end
				end
			end
		end

		if (item.last_byte) begin
			ok = nxt.phase == PH_SUB || nxt.phase == PH_AFTER || nxt.phase == PH_VTOK;
			if (nxt.phase == PH_VTOK && nxt.param_total != 8'hFF) begin
				nxt.param_total = nxt.param_total + 8'd1;
			end
			res.done_res    = 1'b1;
			res.accepted    = ok;
			res.param_count = nxt.param_total;
			nxt             = STATE_RESET;
		end else begin
			res.param_count = nxt.param_total;
		end
	end

endmodule

// File: rtl/content_type_header_parser.sv
// Top level of the Content-Type header parser: input stage, parser state and
// result register. Depends on cthp_pkg, cthp_step and the assertion macro header.
//
// Usage: header bytes enter on the hdr channel (hdr_valid, hdr_stall, hdr), one
// byte per transfer, the final byte of a header marked by last_byte. Every byte
// gives exactly one result on the res channel (res_valid, res_stall, res), in
// order. The result of the marked byte carries done_res, accepted and the final
// parameter count; the parser then starts afresh for the next header.
// Timing: a byte taken waits in the input stage, and its result is registered
// in the result register when the stage advances, which raises res_valid.
// Throughput: one byte per cycle while the receiver does not stall, set by
// the single state update per byte in the parser step logic.
// The input stage keeps accepting while a result waits in the output register;
// when the receiver stalls, the result holds and, once the input stage is also
// full, hdr_stall rises until the result is taken.
// Reset (arst_n low) empties both stages and returns the parser to the leading
// blank phase with all counts cleared.
`include "content_type_header_parser_macros.svh"

module content_type_header_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                hdr_valid,
	output logic                hdr_stall,
	input  cthp_pkg::hdr_item_t hdr,
	output logic                res_valid,
	input  logic                res_stall,
	output cthp_pkg::res_item_t res
);
	import cthp_pkg::*;

	logic         valid_s1;
	hdr_item_t    item_s1;
	logic         res_valid_q;
	res_item_t    res_q;
	parse_state_t state_q;
	parse_state_t state_nxt;
	res_item_t    res_nxt;
	logic         adv;

	cthp_step u_step (
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	assign adv       = valid_s1 && (!res_valid_q || !res_stall);
	assign hdr_stall = valid_s1 && !adv;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!hdr_stall) begin
			valid_s1 <= hdr_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!hdr_stall && hdr_valid) begin
			item_s1 <= hdr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			state_q     <= STATE_RESET;
		end else if (adv) begin
			res_valid_q <= 1'b1;
			state_q     <= state_nxt;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_nxt;
		end
	end

	`CTHP_ASSERT_NEXT(a_last_resets, adv && item_s1.last_byte,
		state_q.phase == PH_LEAD && state_q.param_total == 8'd0)
	`CTHP_ASSERT_NEXT(a_err_sticky, adv && !item_s1.last_byte && state_q.phase == PH_ERR,
		state_q.phase == PH_ERR && res_valid_q && !res_q.char_valid)
	`CTHP_ASSERT_SAME(a_accept_on_done, res_valid_q && res_q.accepted, res_q.done_res)
	`CTHP_ASSERT_SAME(a_no_char_blank, res_valid_q && !res_q.char_valid,
		res_q.out_char == 8'd0 && !res_q.is_charset && !res_q.param_kept)
	`CTHP_ASSERT_NEXT(a_stage_holds, valid_s1 && !adv, valid_s1 && $stable(item_s1))

endmodule
